[rtl/tmrfm_pkg.sv]
// ---------------------------------------------------------------------------
// tmrfm_pkg: shared constants and types of the three-channel RMS fault monitor
// Widths, register map, trip codes and the configuration bundle.
// ---------------------------------------------------------------------------
package tmrfm_pkg;

    // Sampling and window geometry
    localparam int ADC_BITS           = 12;
    localparam int SAMPLES_PER_WINDOW = 16;
    localparam int CHANNELS           = 3;
    localparam int CH_W               = 2;

    localparam int IDX_W     = (SAMPLES_PER_WINDOW > 1) ? $clog2(SAMPLES_PER_WINDOW) : 1;
    localparam int SUM_W     = ADC_BITS + IDX_W;
    localparam int SQ_W      = 2 * ADC_BITS + IDX_W;
    localparam int REM_W     = IDX_W + 1;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    // Result and calibration widths
    localparam int CFG_W         = 16;
    localparam int CAL_W         = 16;
    localparam int RMS_W         = 16;
    localparam int MS_W          = 2 * RMS_W;
    localparam int SHIFT_CURRENT = 10;
    localparam int SHIFT_VOLTAGE = 15;
    localparam int MAC_W         = (SQ_W + CAL_W > SHIFT_VOLTAGE + MS_W) ?
                                   (SQ_W + CAL_W) : (SHIFT_VOLTAGE + MS_W);

    localparam logic [ADC_BITS-1:0] AVG_RESET = ADC_BITS'(2045);

    // Channel codes
    localparam logic [CH_W-1:0] CH_CURRENT  = 2'd0;
    localparam logic [CH_W-1:0] CH_VOLT_ONE = 2'd1;
    localparam logic [CH_W-1:0] CH_VOLT_TWO = 2'd2;

    // Trip codes
    localparam logic [1:0] TRIP_NONE     = 2'd0;
    localparam logic [1:0] TRIP_OVER     = 2'd1;
    localparam logic [1:0] TRIP_COLLAPSE = 2'd2;

    // Register map
    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_CAL_CURRENT     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CAL_VOLTAGE_ONE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CAL_VOLTAGE_TWO = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_NOLOAD_CURRENT  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_NOLOAD_VOLTAGE  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TRIP_HIGH_V1    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TRIP_LOW_V2     = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_COLLAPSE_V1     = 3'd7;

    typedef struct packed {
        logic [CFG_W-1:0] cal_current;
        logic [CFG_W-1:0] cal_voltage_one;
        logic [CFG_W-1:0] cal_voltage_two;
        logic [CFG_W-1:0] noload_current;
        logic [CFG_W-1:0] noload_voltage;
        logic [CFG_W-1:0] trip_high_v1;
        logic [CFG_W-1:0] trip_low_v2;
        logic [CFG_W-1:0] collapse_v1;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        cal_current:     16'd29402,
        cal_voltage_one: 16'd113,
        cal_voltage_two: 16'd113,
        noload_current:  16'd0,
        noload_voltage:  16'd0,
        trip_high_v1:    16'd200,
        trip_low_v2:     16'd150,
        collapse_v1:     16'd50
    };

endpackage

[rtl/tmrfm_if.sv]
// ---------------------------------------------------------------------------
// tmrfm_if: sample and result channels of the RMS fault monitor
// Valid/ready channels; a transfer happens when valid and ready are high.
// ---------------------------------------------------------------------------
interface tmrfm_in_if;
    logic                              valid;
    logic                              ready;
    logic [tmrfm_pkg::ADC_BITS-1:0]    sample_current;
    logic [tmrfm_pkg::ADC_BITS-1:0]    sample_volt_one;
    logic [tmrfm_pkg::ADC_BITS-1:0]    sample_volt_two;
    logic                              timeout_event;

    modport source (
        output valid, sample_current, sample_volt_one, sample_volt_two, timeout_event,
        input  ready
    );
    modport sink (
        input  valid, sample_current, sample_volt_one, sample_volt_two, timeout_event,
        output ready
    );
endinterface

interface tmrfm_out_if;
    logic                           valid;
    logic                           ready;
    logic [tmrfm_pkg::RMS_W-1:0]    rms_current;
    logic [tmrfm_pkg::RMS_W-1:0]    rms_volt_one;
    logic [tmrfm_pkg::RMS_W-1:0]    rms_volt_two;
    logic [1:0]                     trip_code;
    logic [tmrfm_pkg::RMS_W-1:0]    tripped_current;
    logic [tmrfm_pkg::RMS_W-1:0]    tripped_volt_one;
    logic [tmrfm_pkg::RMS_W-1:0]    tripped_volt_two;

    modport source (
        output valid, rms_current, rms_volt_one, rms_volt_two, trip_code,
               tripped_current, tripped_volt_one, tripped_volt_two,
        input  ready
    );
    modport sink (
        input  valid, rms_current, rms_volt_one, rms_volt_two, trip_code,
               tripped_current, tripped_volt_one, tripped_volt_two,
        output ready
    );
endinterface

[rtl/tmrfm_cfg.sv]
// ---------------------------------------------------------------------------
// tmrfm_cfg: APB register file of the RMS fault monitor
// Eight 16-bit registers at word addresses, always ready, read back as stored.
// ---------------------------------------------------------------------------
module tmrfm_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tmrfm_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output tmrfm_pkg::cfg_t                cfg
);
    import tmrfm_pkg::*;

    cfg_t                   cfg_reg;
    cfg_t                   cfg_next;
    logic                   wr_en;
    logic [REG_IDX_W-1:0]   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Decode the write transfer
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_CAL_CURRENT:     cfg_next.cal_current     = pwdata[CFG_W-1:0];
                REG_CAL_VOLTAGE_ONE: cfg_next.cal_voltage_one = pwdata[CFG_W-1:0];
                REG_CAL_VOLTAGE_TWO: cfg_next.cal_voltage_two = pwdata[CFG_W-1:0];
                REG_NOLOAD_CURRENT:  cfg_next.noload_current  = pwdata[CFG_W-1:0];
                REG_NOLOAD_VOLTAGE:  cfg_next.noload_voltage  = pwdata[CFG_W-1:0];
                REG_TRIP_HIGH_V1:    cfg_next.trip_high_v1    = pwdata[CFG_W-1:0];
                REG_TRIP_LOW_V2:     cfg_next.trip_low_v2     = pwdata[CFG_W-1:0];
                REG_COLLAPSE_V1:     cfg_next.collapse_v1     = pwdata[CFG_W-1:0];
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_CAL_CURRENT:     prdata = 32'(cfg_reg.cal_current);
            REG_CAL_VOLTAGE_ONE: prdata = 32'(cfg_reg.cal_voltage_one);
            REG_CAL_VOLTAGE_TWO: prdata = 32'(cfg_reg.cal_voltage_two);
            REG_NOLOAD_CURRENT:  prdata = 32'(cfg_reg.noload_current);
            REG_NOLOAD_VOLTAGE:  prdata = 32'(cfg_reg.noload_voltage);
            REG_TRIP_HIGH_V1:    prdata = 32'(cfg_reg.trip_high_v1);
            REG_TRIP_LOW_V2:     prdata = 32'(cfg_reg.trip_low_v2);
            REG_COLLAPSE_V1:     prdata = 32'(cfg_reg.collapse_v1);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/tmrfm_mac.sv]
// ---------------------------------------------------------------------------
// tmrfm_mac: bit-serial multiply-accumulate unit
// acc = init + mcand * mplier, one multiplier bit per cycle, LSB first; stops
// as soon as the remaining multiplier bits are zero.
// ---------------------------------------------------------------------------
module tmrfm_mac (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tmrfm_pkg::MAC_W-1:0]   init,
    input  logic [tmrfm_pkg::MAC_W-1:0]   mcand,
    input  logic [tmrfm_pkg::CAL_W-1:0]   mplier,
    output logic                          done,
    output logic [tmrfm_pkg::MAC_W-1:0]   acc
);
    import tmrfm_pkg::*;

    logic [MAC_W-1:0]  acc_reg;
    logic [MAC_W-1:0]  acc_next;
    logic [MAC_W-1:0]  mcand_reg;
    logic [MAC_W-1:0]  mcand_next;
    logic [CAL_W-1:0]  mplier_reg;
    logic [CAL_W-1:0]  mplier_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;

    assign done = done_reg;
    assign acc  = acc_reg;

    // Load on start, then add the shifted multiplicand for each set bit
    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            acc_next    = init;
            mcand_next  = mcand;
            mplier_next = mplier;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            if (mplier_next == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

endmodule

[rtl/tmrfm_sqrt.sv]
// ---------------------------------------------------------------------------
// tmrfm_sqrt: digit-serial floor square root
// Shifts in two radicand bits per cycle and settles one root bit per cycle.
// ---------------------------------------------------------------------------
module tmrfm_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tmrfm_pkg::MS_W-1:0]    radicand,
    output logic                          done,
    output logic [tmrfm_pkg::RMS_W-1:0]   root
);
    import tmrfm_pkg::*;

    localparam int SREM_W = RMS_W + 1;
    localparam int PART_W = RMS_W + 3;
    localparam int CNT_W  = $clog2(RMS_W);

    logic [MS_W-1:0]    rad_reg;
    logic [MS_W-1:0]    rad_next;
    logic [SREM_W-1:0]  rem_reg;
    logic [SREM_W-1:0]  rem_next;
    logic [RMS_W-1:0]   root_reg;
    logic [RMS_W-1:0]   root_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               busy_reg;
    logic               busy_next;
    logic               done_reg;
    logic               done_next;
    logic [PART_W-1:0]  part;
    logic [PART_W-1:0]  trial;
    logic [PART_W-1:0]  diff;

    assign done  = done_reg;
    assign root  = root_reg;
    assign part  = {rem_reg, rad_reg[MS_W-1 -: 2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign diff  = part - trial;

    // Try the next root bit against the running remainder
    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = rad_reg << 2;
            cnt_next = cnt_reg + CNT_W'(1);
            if (part >= trial)
            begin
                rem_next  = diff[SREM_W-1:0];
                root_next = {root_reg[RMS_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = part[SREM_W-1:0];
                root_next = {root_reg[RMS_W-2:0], 1'b0};
            end
            if (cnt_reg == CNT_W'(RMS_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

endmodule

[rtl/three_channel_rms_fault_monitor.sv]
// An ordinary sample's time depends on L, the bit length of each channel's deviation
// (at least 1), and is set by the bit-serial multiply-accumulate.
// The window-closing sample adds serial averaging, per channel a calibration
// multiply and a square root, and one publish step.
// rst_n clears averages to 2045, sums, maxima and flags; no clearing pass is needed.
// ---------------------------------------------------------------------------
// three_channel_rms_fault_monitor: top level
// Accumulates squared deviations per window, derives calibrated RMS values,
// tracks the maximum set and classifies trips.
// ---------------------------------------------------------------------------
module three_channel_rms_fault_monitor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tmrfm_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    tmrfm_in_if.sink                       samples,
    tmrfm_out_if.source                    results
);
    import tmrfm_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SQ_GO    = 4'd1;
    localparam logic [3:0] S_SQ_WAIT  = 4'd2;
    localparam logic [3:0] S_DIV      = 4'd3;
    localparam logic [3:0] S_AVG      = 4'd4;
    localparam logic [3:0] S_CAL_GO   = 4'd5;
    localparam logic [3:0] S_CAL_WAIT = 4'd6;
    localparam logic [3:0] S_RT_WAIT  = 4'd7;
    localparam logic [3:0] S_FINAL    = 4'd8;

    cfg_t cfg;

    logic [3:0]            state_reg;
    logic [3:0]            state_next;
    logic [CH_W-1:0]       ch_reg;
    logic [CH_W-1:0]       ch_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_next;
    logic                  pending_reg;
    logic                  pending_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    logic [ADC_BITS-1:0]   sample_reg  [CHANNELS];
    logic [ADC_BITS-1:0]   sample_next [CHANNELS];
    logic [ADC_BITS-1:0]   avg_reg     [CHANNELS];
    logic [ADC_BITS-1:0]   avg_next    [CHANNELS];
    logic [SUM_W-1:0]      raw_reg     [CHANNELS];
    logic [SUM_W-1:0]      raw_next    [CHANNELS];
    logic [IDX_W-1:0]      rem_reg     [CHANNELS];
    logic [IDX_W-1:0]      rem_next    [CHANNELS];
    logic [SQ_W-1:0]       sq_reg      [CHANNELS];
    logic [SQ_W-1:0]       sq_next     [CHANNELS];
    logic [RMS_W-1:0]      rms_reg     [CHANNELS];
    logic [RMS_W-1:0]      rms_next    [CHANNELS];
    logic [RMS_W-1:0]      max_reg     [CHANNELS];
    logic [RMS_W-1:0]      max_next    [CHANNELS];
    logic [RMS_W-1:0]      out_rms_reg  [CHANNELS];
    logic [RMS_W-1:0]      out_rms_next [CHANNELS];
    logic [RMS_W-1:0]      out_snap_reg  [CHANNELS];
    logic [RMS_W-1:0]      out_snap_next [CHANNELS];
    logic [1:0]            out_trip_reg;
    logic [1:0]            out_trip_next;

    logic [ADC_BITS-1:0]   in_sample [CHANNELS];
    logic [REM_W-1:0]      div_part  [CHANNELS];
    logic                  div_q     [CHANNELS];
    logic [REM_W-1:0]      div_diff  [CHANNELS];
    logic [RMS_W-1:0]      max_upd   [CHANNELS];

    logic                  in_fire;
    logic                  out_fire;
    logic [ADC_BITS-1:0]   cur_sample;
    logic [ADC_BITS-1:0]   cur_avg;
    logic [SQ_W-1:0]       cur_sq;
    logic [CAL_W-1:0]      cur_cal;
    logic [ADC_BITS-1:0]   mag;

    logic                  mac_start;
    logic [MAC_W-1:0]      mac_init;
    logic [MAC_W-1:0]      mac_mcand;
    logic [CAL_W-1:0]      mac_mplier;
    logic                  mac_done;
    logic [MAC_W-1:0]      mac_acc;
    logic                  rt_start;
    logic [MS_W-1:0]       rt_radicand;
    logic                  rt_done;
    logic [RMS_W-1:0]      rt_root;
    logic [RMS_W-1:0]      root_z;

    logic                  max_take;
    logic                  trip_over;
    logic                  trip_collapse;
    logic                  tripped;

    tmrfm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tmrfm_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mac_start),
        .init   (mac_init),
        .mcand  (mac_mcand),
        .mplier (mac_mplier),
        .done   (mac_done),
        .acc    (mac_acc)
    );

    tmrfm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rt_start),
        .radicand (rt_radicand),
        .done     (rt_done),
        .root     (rt_root)
    );

    // Channel handshakes
    assign samples.ready = (state_reg == S_IDLE);
    assign in_fire       = samples.valid && samples.ready;
    assign out_fire      = out_valid_reg && results.ready;

    assign in_sample[0] = samples.sample_current;
    assign in_sample[1] = samples.sample_volt_one;
    assign in_sample[2] = samples.sample_volt_two;

    assign results.valid            = out_valid_reg;
    assign results.rms_current      = out_rms_reg[0];
    assign results.rms_volt_one     = out_rms_reg[1];
    assign results.rms_volt_two     = out_rms_reg[2];
    assign results.trip_code        = out_trip_reg;
    assign results.tripped_current  = out_snap_reg[0];
    assign results.tripped_volt_one = out_snap_reg[1];
    assign results.tripped_volt_two = out_snap_reg[2];

    // Select the active channel's operands
    always_comb
    begin
        case (ch_reg)
            CH_CURRENT:
            begin
                cur_sample = sample_reg[0];
                cur_avg    = avg_reg[0];
                cur_sq     = sq_reg[0];
                cur_cal    = cfg.cal_current;
            end
            CH_VOLT_ONE:
            begin
                cur_sample = sample_reg[1];
                cur_avg    = avg_reg[1];
                cur_sq     = sq_reg[1];
                cur_cal    = cfg.cal_voltage_one;
            end
            CH_VOLT_TWO:
            begin
                cur_sample = sample_reg[2];
                cur_avg    = avg_reg[2];
                cur_sq     = sq_reg[2];
                cur_cal    = cfg.cal_voltage_two;
            end
            default:
            begin
                cur_sample = '0;
                cur_avg    = '0;
                cur_sq     = '0;
                cur_cal    = '0;
            end
        endcase
    end

    // Absolute deviation from the running average
    assign mag = (cur_sample >= cur_avg) ? (cur_sample - cur_avg) : (cur_avg - cur_sample);

    // Square-accumulate in the sample phase, calibrate at window end
    assign mac_start  = (state_reg == S_SQ_GO) || (state_reg == S_CAL_GO);
    assign mac_init   = (state_reg == S_SQ_GO) ? MAC_W'(cur_sq) : '0;
    assign mac_mcand  = (state_reg == S_SQ_GO) ? MAC_W'(mag) : MAC_W'(cur_sq);
    assign mac_mplier = (state_reg == S_SQ_GO) ? CAL_W'(mag) : cur_cal;

    // Scale, wrap and hand to the square root
    assign rt_start    = (state_reg == S_CAL_WAIT) && mac_done;
    assign rt_radicand = (ch_reg == CH_CURRENT) ? mac_acc[SHIFT_CURRENT +: MS_W]
                                                : mac_acc[SHIFT_VOLTAGE +: MS_W];

    // Apply the no-load floor
    always_comb
    begin
        root_z = rt_root;
        if (ch_reg == CH_CURRENT)
        begin
            if (rt_root <= cfg.noload_current)
            begin
                root_z = '0;
            end
        end
        else if (rt_root < cfg.noload_voltage)
        begin
            root_z = '0;
        end
    end

    // One restoring division step per cycle on each raw sum
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            div_part[c] = {rem_reg[c], raw_reg[c][SUM_W-1]};
            div_q[c]    = (div_part[c] >= REM_W'(SAMPLES_PER_WINDOW));
            div_diff[c] = div_part[c] - REM_W'(SAMPLES_PER_WINDOW);
        end
    end

    // Maximum set and trip classification
    assign max_take      = (max_reg[0] <= rms_reg[0]);
    assign trip_over     = (rms_reg[1] > cfg.trip_high_v1) && (rms_reg[2] < cfg.trip_low_v2);
    assign trip_collapse = (rms_reg[1] < cfg.collapse_v1);
    assign tripped       = trip_over || trip_collapse;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            max_upd[c] = max_take ? rms_reg[c] : max_reg[c];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        idx_next       = idx_reg;
        div_cnt_next   = div_cnt_reg;
        pending_next   = pending_reg;
        out_valid_next = out_fire ? 1'b0 : out_valid_reg;
        out_trip_next  = out_trip_reg;
        sample_next    = sample_reg;
        avg_next       = avg_reg;
        raw_next       = raw_reg;
        rem_next       = rem_reg;
        sq_next        = sq_reg;
        rms_next       = rms_reg;
        max_next       = max_reg;
        out_rms_next   = out_rms_reg;
        out_snap_next  = out_snap_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // Take the sample transfer and add the raw values
                if (in_fire)
                begin
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        sample_next[c] = in_sample[c];
                        raw_next[c]    = raw_reg[c] + SUM_W'(in_sample[c]);
                    end
                    if (samples.timeout_event)
                    begin
                        pending_next = 1'b1;
                    end
                    ch_next    = CH_CURRENT;
                    state_next = S_SQ_GO;
                end
            end
            S_SQ_GO:
            begin
                state_next = S_SQ_WAIT;
            end
            S_SQ_WAIT:
            begin
                if (mac_done)
                begin
                    sq_next[ch_reg] = mac_acc[SQ_W-1:0];
                    if (ch_reg == CH_VOLT_TWO)
                    begin
                        if (idx_reg == IDX_W'(SAMPLES_PER_WINDOW - 1))
                        begin
                            idx_next     = '0;
                            div_cnt_next = '0;
                            for (int c = 0; c < CHANNELS; c++)
                            begin
                                rem_next[c] = '0;
                            end
                            state_next = S_DIV;
                        end
                        else
                        begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        ch_next    = ch_reg + CH_W'(1);
                        state_next = S_SQ_GO;
                    end
                end
            end
            S_DIV:
            begin
                // Shift quotient bits into the raw sums
                for (int c = 0; c < CHANNELS; c++)
                begin
                    rem_next[c] = div_q[c] ? div_diff[c][IDX_W-1:0] : div_part[c][IDX_W-1:0];
                    raw_next[c] = {raw_reg[c][SUM_W-2:0], div_q[c]};
                end
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(SUM_W - 1))
                begin
                    state_next = S_AVG;
                end
            end
            S_AVG:
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    avg_next[c] = raw_reg[c][ADC_BITS-1:0];
                    raw_next[c] = '0;
                end
                ch_next    = CH_CURRENT;
                state_next = S_CAL_GO;
            end
            S_CAL_GO:
            begin
                // Square sum is now held in the multiplier; clear it
                sq_next[ch_reg] = '0;
                state_next      = S_CAL_WAIT;
            end
            S_CAL_WAIT:
            begin
                if (mac_done)
                begin
                    state_next = S_RT_WAIT;
                end
            end
            S_RT_WAIT:
            begin
                if (rt_done)
                begin
                    rms_next[ch_reg] = root_z;
                    if (ch_reg == CH_VOLT_TWO)
                    begin
                        state_next = S_FINAL;
                    end
                    else
                    begin
                        ch_next    = ch_reg + CH_W'(1);
                        state_next = S_CAL_GO;
                    end
                end
            end
            S_FINAL:
            begin
                // Publish once the output register is free
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    if (trip_over)
                    begin
                        out_trip_next = TRIP_OVER;
                    end
                    else if (trip_collapse)
                    begin
                        out_trip_next = TRIP_COLLAPSE;
                    end
                    else
                    begin
                        out_trip_next = TRIP_NONE;
                    end
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        out_rms_next[c]  = rms_reg[c];
                        out_snap_next[c] = tripped ? max_upd[c] : rms_reg[c];
                        max_next[c]      = (!tripped && pending_reg) ? rms_reg[c] : max_upd[c];
                    end
                    if (!tripped)
                    begin
                        pending_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= CH_CURRENT;
            idx_reg       <= '0;
            div_cnt_reg   <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                avg_reg[c] <= AVG_RESET;
                raw_reg[c] <= '0;
                sq_reg[c]  <= '0;
                max_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            idx_reg       <= idx_next;
            div_cnt_reg   <= div_cnt_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
            avg_reg       <= avg_next;
            raw_reg       <= raw_next;
            sq_reg        <= sq_next;
            max_reg       <= max_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        rem_reg      <= rem_next;
        rms_reg      <= rms_next;
        out_rms_reg  <= out_rms_next;
        out_snap_reg <= out_snap_next;
        out_trip_reg <= out_trip_next;
    end

endmodule

[dv/rms_window_checker.sv]
// ---------------------------------------------------------------------------
// rms_window_checker: predicts and checks the RMS fault monitor's reports
// Follows register writes on the APB port and every sample transfer, keeps
// its own averages, sums and maximum set, and computes the report of each
// finished window. Report transfers are compared in order, field by field.
// Register reads are checked against the tracked register values.
// ---------------------------------------------------------------------------
module rms_window_checker
    import tmrfm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    input  logic [31:0]        prdata,
    input  logic               pready,
    tmrfm_in_if                samples,
    tmrfm_out_if               results,
    output int                 fail_count,
    output int                 outstanding
);

    typedef struct {
        logic [RMS_W-1:0] rms_current;
        logic [RMS_W-1:0] rms_volt_one;
        logic [RMS_W-1:0] rms_volt_two;
        logic [1:0]       trip_code;
        logic [RMS_W-1:0] tripped_current;
        logic [RMS_W-1:0] tripped_volt_one;
        logic [RMS_W-1:0] tripped_volt_two;
    } rms_report_t;

    // Tracked register file and window state
    logic [CFG_W-1:0]    reg_file [8];
    int                  window_fill;
    logic [ADC_BITS-1:0] running_avg [CHANNELS];
    longint unsigned     raw_total [CHANNELS];
    longint unsigned     dev_sq_total [CHANNELS];
    logic [RMS_W-1:0]    peak_set [CHANNELS];
    bit                  max_reset_pending;
    rms_report_t         pending_reports [$];
    int                  errors = 0;

    // Floor square root, built one result bit at a time from the top
    function automatic logic [RMS_W-1:0] floor_root(logic [MS_W-1:0] value);
        logic [RMS_W-1:0] root;
        logic [RMS_W-1:0] trial;
        root = '0;
        for (int b = RMS_W - 1; b >= 0; b--) begin
            trial = root | (RMS_W'(1) << b);
            if (longint'(trial) * longint'(trial) <= longint'(value))
                root = trial;
        end
        return root;
    endfunction

    task automatic check_field(string label, logic [RMS_W-1:0] want, logic [RMS_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    // Close the window: new averages, calibrated RMS, maximum set and trip class
    task automatic close_window();
        logic [RMS_W-1:0] rms [CHANNELS];
        logic [RMS_W-1:0] snap [CHANNELS];
        logic [1:0]       trip;
        longint unsigned  gain;
        logic [MS_W-1:0]  mean_sq;
        int               shift;
        rms_report_t      rep;
        for (int c = 0; c < CHANNELS; c++) begin
            gain  = (c == CH_CURRENT)  ? reg_file[REG_CAL_CURRENT] :
                    (c == CH_VOLT_ONE) ? reg_file[REG_CAL_VOLTAGE_ONE] :
                                         reg_file[REG_CAL_VOLTAGE_TWO];
            shift = (c == CH_CURRENT) ? SHIFT_CURRENT : SHIFT_VOLTAGE;
            mean_sq = MS_W'((dev_sq_total[c] * gain) >> shift);
            running_avg[c]  = ADC_BITS'(raw_total[c] / SAMPLES_PER_WINDOW);
            raw_total[c]    = 0;
            dev_sq_total[c] = 0;
            rms[c] = floor_root(mean_sq);
        end

        // No-load zeroing: current at or below, voltages strictly below
        if (rms[CH_CURRENT] <= reg_file[REG_NOLOAD_CURRENT])
            rms[CH_CURRENT] = '0;
        if (rms[CH_VOLT_ONE] < reg_file[REG_NOLOAD_VOLTAGE])
            rms[CH_VOLT_ONE] = '0;
        if (rms[CH_VOLT_TWO] < reg_file[REG_NOLOAD_VOLTAGE])
            rms[CH_VOLT_TWO] = '0;

        // Replace the maximum set before the trip decision
        if (peak_set[CH_CURRENT] <= rms[CH_CURRENT])
            peak_set = rms;

        // Overvoltage with low second channel wins over collapse
        if (rms[CH_VOLT_ONE] > reg_file[REG_TRIP_HIGH_V1] &&
            rms[CH_VOLT_TWO] < reg_file[REG_TRIP_LOW_V2]) begin
            trip = TRIP_OVER;
            snap = peak_set;
        end else if (rms[CH_VOLT_ONE] < reg_file[REG_COLLAPSE_V1]) begin
            trip = TRIP_COLLAPSE;
            snap = peak_set;
        end else begin
            trip = TRIP_NONE;
            snap = rms;
            // A pending timeout is only consumed by a window without a trip
            if (max_reset_pending) begin
                max_reset_pending = 1'b0;
                peak_set = rms;
            end
        end

        rep.rms_current      = rms[CH_CURRENT];
        rep.rms_volt_one     = rms[CH_VOLT_ONE];
        rep.rms_volt_two     = rms[CH_VOLT_TWO];
        rep.trip_code        = trip;
        rep.tripped_current  = snap[CH_CURRENT];
        rep.tripped_volt_one = snap[CH_VOLT_ONE];
        rep.tripped_volt_two = snap[CH_VOLT_TWO];
        pending_reports.push_back(rep);
    endtask

    // Accumulate one sample transfer; the timeout is latched before the window end
    task automatic accumulate_sample(logic [ADC_BITS-1:0] s_cur, logic [ADC_BITS-1:0] s_v1,
                                     logic [ADC_BITS-1:0] s_v2, logic tmo);
        logic [ADC_BITS-1:0] s [CHANNELS];
        int                  dev;
        s[CH_CURRENT]  = s_cur;
        s[CH_VOLT_ONE] = s_v1;
        s[CH_VOLT_TWO] = s_v2;
        for (int c = 0; c < CHANNELS; c++) begin
            dev = int'(s[c]) - int'(running_avg[c]);
            raw_total[c]    += s[c];
            dev_sq_total[c] += longint'(dev * dev);
        end
        if (tmo)
            max_reset_pending = 1'b1;
        window_fill++;
        if (window_fill == SAMPLES_PER_WINDOW) begin
            window_fill = 0;
            close_window();
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : monitor
        rms_report_t want;
        if (!rst_n) begin
            reg_file[REG_CAL_CURRENT]     = CFG_RESET.cal_current;
            reg_file[REG_CAL_VOLTAGE_ONE] = CFG_RESET.cal_voltage_one;
            reg_file[REG_CAL_VOLTAGE_TWO] = CFG_RESET.cal_voltage_two;
            reg_file[REG_NOLOAD_CURRENT]  = CFG_RESET.noload_current;
            reg_file[REG_NOLOAD_VOLTAGE]  = CFG_RESET.noload_voltage;
            reg_file[REG_TRIP_HIGH_V1]    = CFG_RESET.trip_high_v1;
            reg_file[REG_TRIP_LOW_V2]     = CFG_RESET.trip_low_v2;
            reg_file[REG_COLLAPSE_V1]     = CFG_RESET.collapse_v1;
            window_fill       = 0;
            max_reset_pending = 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                running_avg[c]  = AVG_RESET;
                raw_total[c]    = 0;
                dev_sq_total[c] = 0;
                peak_set[c]     = '0;
            end
            pending_reports.delete();
        end else begin
            // Compare a report transfer with the oldest prediction
            if (results.valid && results.ready) begin
                if (pending_reports.size() == 0) begin
                    errors++;
                    $display("%0t unexpected report: expected none, actual rms %0d/%0d/%0d trip %0d",
                             $time, results.rms_current, results.rms_volt_one,
                             results.rms_volt_two, results.trip_code);
                end else begin
                    want = pending_reports.pop_front();
                    check_field("rms_current", want.rms_current, results.rms_current);
                    check_field("rms_volt_one", want.rms_volt_one, results.rms_volt_one);
                    check_field("rms_volt_two", want.rms_volt_two, results.rms_volt_two);
                    check_field("trip_code", RMS_W'(want.trip_code), RMS_W'(results.trip_code));
                    check_field("tripped_current", want.tripped_current,
                                results.tripped_current);
                    check_field("tripped_volt_one", want.tripped_volt_one,
                                results.tripped_volt_one);
                    check_field("tripped_volt_two", want.tripped_volt_two,
                                results.tripped_volt_two);
                end
            end

            if (samples.valid && samples.ready)
                accumulate_sample(samples.sample_current, samples.sample_volt_one,
                                  samples.sample_volt_two, samples.timeout_event);

            // Track register writes, check register reads
            if (psel && penable && pready) begin
                if (pwrite)
                    reg_file[paddr[PADDR_W-1:2]] = pwdata[CFG_W-1:0];
                else
                    check_field("register read", reg_file[paddr[PADDR_W-1:2]],
                                prdata[CFG_W-1:0]);
            end
        end
        fail_count  <= errors;
        outstanding <= pending_reports.size();
    end

endmodule

[dv/three_channel_rms_fault_monitor_tb.sv]
// ---------------------------------------------------------------------------
// three_channel_rms_fault_monitor_tb: testbench top of the RMS fault monitor
// Drives sample windows with shaped random waveforms and timeout events,
// uses the reset values first, then programs the registers between phases
// (all ones, all zeros, random), stalls both channels at random and gives
// the verdict. Prediction and comparison live in rms_window_checker.
// ---------------------------------------------------------------------------
module three_channel_rms_fault_monitor_tb;
    import tmrfm_pkg::*;

    // Longest quiet stretch of a correct run is the long hold plus the
    // processing of one window plus settling and register traffic
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int LONG_HOLD      = 3000;
    localparam int PHASE_ITEMS    = 140;
    localparam int FIRST_RANDOM   = 136;
    localparam logic [ADC_BITS-1:0] ADC_MAX = '1;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    tmrfm_in_if  samples ();
    tmrfm_out_if results ();

    int  fail_count;
    int  outstanding;
    int  idle_cycles = 0;
    int  items_sent  = 0;
    bit  hold_output = 1'b0;
    bit  quiet_tail  = 1'b0;

    // Waveform shape of the current window
    logic [ADC_BITS-1:0] wave_center [CHANNELS];
    int                  wave_amp [CHANNELS];
    int                  wave_mode [CHANNELS];
    bit                  window_idles;

    three_channel_rms_fault_monitor dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (samples),
        .results (results)
    );

    rms_window_checker window_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .samples     (samples),
        .results     (results),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // One APB access: setup cycle, access cycle, then a free cycle
    task automatic apb_access(bit is_write, logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= 32'(data);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write every register, then read each back
    task automatic program_config(input logic [CFG_W-1:0] regs [8]);
        for (int i = 0; i < 8; i++)
            apb_access(1'b1, REG_IDX_W'(i), regs[i]);
        for (int i = 0; i < 8; i++)
            apb_access(1'b0, REG_IDX_W'(i), '0);
    endtask

    task automatic draw_settings(output logic [CFG_W-1:0] regs [8]);
        regs[REG_CAL_CURRENT]     = CFG_W'($urandom_range(0, 65535));
        regs[REG_CAL_VOLTAGE_ONE] = CFG_W'($urandom_range(0, 65535));
        regs[REG_CAL_VOLTAGE_TWO] = CFG_W'($urandom_range(0, 65535));
        regs[REG_NOLOAD_CURRENT]  = CFG_W'($urandom_range(0, 2000));
        regs[REG_NOLOAD_VOLTAGE]  = CFG_W'($urandom_range(0, 300));
        regs[REG_TRIP_HIGH_V1]    = CFG_W'($urandom_range(0, 1500));
        regs[REG_TRIP_LOW_V2]     = CFG_W'($urandom_range(0, 1500));
        regs[REG_COLLAPSE_V1]     = CFG_W'($urandom_range(0, 600));
    endtask

    // Offer one sample, optionally after an idle burst, and hold it until transferred
    task automatic send_sample(logic [ADC_BITS-1:0] s_cur, logic [ADC_BITS-1:0] s_v1,
                               logic [ADC_BITS-1:0] s_v2, bit tmo, bit may_idle);
        if (may_idle && $urandom_range(0, 2) == 0) begin
            samples.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        samples.valid           <= 1'b1;
        samples.sample_current  <= s_cur;
        samples.sample_volt_one <= s_v1;
        samples.sample_volt_two <= s_v2;
        samples.timeout_event   <= tmo;
        do @(posedge clk); while (!samples.ready);
        items_sent++;
    endtask

    // Drop valid and wait until every report has arrived and the block settled
    task automatic drain_results();
        samples.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [ADC_BITS-1:0] shape_sample(logic [ADC_BITS-1:0] center, int amp);
        int v;
        v = int'(center) + int'($urandom_range(0, 2 * amp)) - amp;
        if (v < 0)
            v = 0;
        if (v > int'(ADC_MAX))
            v = int'(ADC_MAX);
        return ADC_BITS'(v);
    endfunction

    // Random windows: mostly a noisy waveform per channel, some pure noise or rail values
    task automatic run_random_items(int count, bit idle_ok);
        logic [ADC_BITS-1:0] pick [CHANNELS];
        for (int n = 0; n < count; n++) begin
            if (items_sent % SAMPLES_PER_WINDOW == 0) begin
                window_idles = idle_ok && ($urandom_range(0, 1) == 1);
                for (int c = 0; c < CHANNELS; c++) begin
                    wave_mode[c]   = $urandom_range(0, 9);
                    wave_center[c] = ADC_BITS'($urandom_range(0, 4095));
                    wave_amp[c]    = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 40)
                                                                  : $urandom_range(0, 2047);
                end
            end
            for (int c = 0; c < CHANNELS; c++) begin
                case (wave_mode[c])
                    0:       pick[c] = ADC_BITS'($urandom_range(0, 4095));
                    1:       pick[c] = ($urandom_range(0, 1) == 1) ? ADC_MAX : '0;
                    default: pick[c] = shape_sample(wave_center[c], wave_amp[c]);
                endcase
            end
            send_sample(pick[CH_CURRENT], pick[CH_VOLT_ONE], pick[CH_VOLT_TWO],
                        $urandom_range(0, 11) == 0, window_idles);
        end
    endtask

    // Report sink: random stalls, one long hold on request, none in the tail
    initial
    begin
        results.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_output) begin
                hold_output = 1'b0;
                results.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                results.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end else begin
                results.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Watchdog: count cycles without any transfer
    always @(posedge clk)
    begin
        if ((samples.valid && samples.ready) || (results.valid && results.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("** three_channel_rms_fault_monitor: FAILED **");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        logic [CFG_W-1:0] regs [8];
        rst_n                   <= 1'b0;
        psel                    <= 1'b0;
        penable                 <= 1'b0;
        pwrite                  <= 1'b0;
        paddr                   <= '0;
        pwdata                  <= '0;
        samples.valid           <= 1'b0;
        samples.sample_current  <= '0;
        samples.sample_volt_one <= '0;
        samples.sample_volt_two <= '0;
        samples.timeout_event   <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Rail-to-rail window with an early timeout, at reset settings
        for (int n = 0; n < SAMPLES_PER_WINDOW; n++)
            send_sample(n[0] ? ADC_MAX : '0, n[0] ? '0 : ADC_MAX, n[1] ? ADC_MAX : '0,
                        n == 2, 1'b1);
        // Flat samples at the new average: zero deviation, timeout while pending
        for (int n = 0; n < 8; n++)
            send_sample(ADC_BITS'(2047), ADC_BITS'(2047), ADC_BITS'(2047), n == 4, 1'b0);
        run_random_items(FIRST_RANDOM, 1'b1);

        // All ones: calibration overflow, everything below no-load; long sink hold
        drain_results();
        regs = '{default: '1};
        program_config(regs);
        hold_output = 1'b1;
        run_random_items(PHASE_ITEMS, 1'b1);

        // All zeros: zero calibration, no trips possible
        drain_results();
        regs = '{default: '0};
        program_config(regs);
        run_random_items(PHASE_ITEMS, 1'b1);

        drain_results();
        draw_settings(regs);
        program_config(regs);
        run_random_items(PHASE_ITEMS, 1'b1);

        // Tail with no idling on either side
        drain_results();
        draw_settings(regs);
        program_config(regs);
        quiet_tail = 1'b1;
        run_random_items(PHASE_ITEMS, 1'b0);

        drain_results();
        if (fail_count == 0)
            $display("** three_channel_rms_fault_monitor: PASSED **");
        else
            $display("** three_channel_rms_fault_monitor: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
rtl/tmrfm_pkg.sv
rtl/tmrfm_if.sv
rtl/tmrfm_cfg.sv
rtl/tmrfm_mac.sv
rtl/tmrfm_sqrt.sv
rtl/three_channel_rms_fault_monitor.sv
dv/rms_window_checker.sv
dv/three_channel_rms_fault_monitor_tb.sv
